>>> rtl/icf_pkg.sv
`default_nettype none
package icf_pkg;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned AngleW = 32;
  localparam int unsigned WeightW = 17;
  localparam int unsigned GainW  = 32;
  localparam int unsigned MaxIter = 24;

  localparam logic [WeightW-1:0] WeightOne   = 17'd65536;
  localparam logic [WeightW-1:0] WeightReset = 17'd1311;
  localparam logic [GainW-1:0]   GainReset   = 32'd2621440;

  // ninety degrees in q15.16
  localparam logic signed [AngleW-1:0] DegNinety = 32'sd5898240;

  localparam logic [0:0] RegWeight = 1'b0;
  localparam logic [0:0] RegGain   = 1'b1;

  function automatic logic signed [AngleW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AngleW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/icf_isqrt.sv
`default_nettype none
// bit-serial square root, one result bit per cycle
module icf_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [56:0] rad_i,
  output logic        done_o,
  output logic [28:0] root_o
);

  logic [57:0] rem_q, rem_d;
  logic [28:0] root_q, root_d;
  logic [57:0] rad_q, rad_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [57:0] trial;
  logic [57:0] shifted;

  // radicand taken as 58 bits, two bits per step, top pair first
  assign shifted = {rem_q[55:0], rad_q[57:56]};
  assign trial   = {27'd0, root_q, 2'b01};

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      rad_d  = {1'b0, rad_i};
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[27:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[27:0], 1'b0};
      end
      rad_d = {rad_q[55:0], 2'b00};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd28) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign root_o = root_d;
endmodule
`default_nettype wire

>>> rtl/icf_cordic.sv
`default_nettype none
// vectoring cordic, one micro-rotation per cycle
module icf_cordic #(
  parameter int unsigned Iterations = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [31:0]               x_i,
  input  logic signed [31:0]               y_i,
  output logic                             done_o,
  output logic signed [icf_pkg::AngleW-1:0] z_o
);
  import icf_pkg::*;

  localparam int unsigned NIter = (Iterations > MaxIter) ? MaxIter : Iterations;

  logic signed [33:0] x_q, y_q;
  logic signed [AngleW-1:0] z_q;
  logic [4:0] i_q;
  logic busy_q;
  logic signed [33:0] xs, ys;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign done_o = busy_q && (i_q == 5'(NIter - 1));
  assign z_o = (y_q > 0) ? z_q + atan_lut(i_q) : z_q - atan_lut(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 5'd1;
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= 34'(x_i);
      y_q <= 34'(y_i);
      z_q <= '0;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
      end
      z_q <= z_o;
    end
  end
endmodule
`default_nettype wire

>>> rtl/imu_complementary_filter.sv
`default_nettype none
// attitude estimator: each beat of six imu samples yields one beat of roll, pitch
// and yaw in q15.16 degrees. per axis a tilt angle is built from the accelerometer
// (a start step and a bit-serial square root, then a start step and a vectoring
// cordic), the kept angle is advanced by gyro times gain and blended with that tilt
// by accel_weight, using one shared 34x34 multiplier in turn. the axes are worked
// one after another, and the input is not ready while an item is in flight, so a
// new item is taken only once the last one is handed off. the result sits in an
// output register and the next sample is taken while it waits; an item only stalls
// in its last step when the previous result has still not been taken.
module imu_complementary_filter #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle
  output logic [95:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import icf_pkg::*;

  localparam logic [3:0] StIdle = 4'd0, StSqrt = 4'd1, StWaitSq = 4'd2, StCord = 4'd3,
                         StWaitCo = 4'd4, StMulG = 4'd5, StMulA = 4'd6, StMulB = 4'd7,
                         StSum = 4'd8;

  logic [WeightW-1:0] weight_q;
  logic [GainW-1:0]   gain_q;
  logic signed [AngleW-1:0] kept_q [3];
  logic signed [15:0] smp_q [6];
  logic [3:0] st_q;
  logic [1:0] ax_q;
  logic signed [AngleW-1:0] acc_q;
  logic signed [63:0] pred_q, term_q;
  logic [95:0] out_q;
  logic out_v_q;
  logic [28:0] hyp_q;

  // register access
  assign pready = 1'b1;
  logic wr;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightReset;
      gain_q   <= GainReset;
    end else if (wr && paddr[2] == RegWeight[0]) begin
      weight_q <= pwdata[WeightW-1:0];
    end else if (wr && paddr[2] == RegGain[0]) begin
      gain_q <= pwdata;
    end
  end
  assign prdata = (paddr[2] == RegWeight[0]) ? {15'd0, weight_q} : gain_q;

  // per-axis operand select
  logic signed [15:0] a, b, c, g;
  always_comb begin
    unique case (ax_q)
      2'd0: begin a = smp_q[1]; b = smp_q[0]; c = smp_q[2]; g = smp_q[3]; end
      2'd1: begin a = smp_q[0]; b = smp_q[1]; c = smp_q[2]; g = smp_q[4]; end
      default: begin a = smp_q[2]; b = smp_q[0]; c = smp_q[1]; g = smp_q[5]; end
    endcase
  end

  // squares are never negative, at most 2^30 each
  logic signed [31:0] bb, cc;
  assign bb = b * b;
  assign cc = c * c;

  logic [56:0] rad;
  assign rad = {({1'b0, bb} + {1'b0, cc}), 24'd0};

  logic sq_done; logic [28:0] sq_root;
  icf_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(st_q == StSqrt), .rad_i(rad),
                    .done_o(sq_done), .root_o(sq_root));

  logic co_done; logic signed [AngleW-1:0] co_z;
  icf_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cordic (.clk_i, .rst_ni,
    .start_i(st_q == StCord), .x_i({3'd0, hyp_q}), .y_i(32'(a) <<< 12),
    .done_o(co_done), .z_o(co_z));

  // shared multiplier
  logic signed [33:0] m_a, m_b;
  logic signed [67:0] m_p;
  logic [WeightW-1:0] w_eff;
  assign w_eff = (weight_q > WeightOne) ? WeightOne : weight_q;
  always_comb begin
    unique case (st_q)
      StMulG:  begin m_a = 34'(g); m_b = {2'b00, gain_q}; end
      StMulA:  begin m_a = {17'd0, w_eff}; m_b = 34'(acc_q); end
      default: begin m_a = {16'd0, 18'(WeightOne) - 18'(w_eff)}; m_b = 34'(pred_q); end
    endcase
  end
  assign m_p = m_a * m_b;

  logic signed [63:0] sum, blendv;
  logic signed [AngleW-1:0] sat;
  assign sum = term_q + 64'(m_p) + 64'sd32768;
  assign blendv = sum >>> 16;
  assign sat = (blendv > 64'sd2147483647) ? 32'sh7fffffff :
               (blendv < -64'sd2147483648) ? 32'sh80000000 : blendv[31:0];

  // last axis done and the output register free or emptied this cycle
  logic hand_off;
  assign hand_off = (st_q == StSum) && (ax_q == 2'd2) && (!out_v_q || m_axis_tready);

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ax_q <= '0;
      out_v_q <= 1'b0;
      for (int k = 0; k < 3; k++) kept_q[k] <= '0;
    end else begin
      if (hand_off) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (s_axis_tvalid) begin
          for (int k = 0; k < 6; k++) smp_q[k] <= s_axis_tdata[16*k +: 16];
          ax_q <= 2'd0;
          st_q <= StSqrt;
        end
        StSqrt: st_q <= StWaitSq;
        StWaitSq: if (sq_done) begin
          hyp_q <= sq_root;
          st_q <= StCord;
        end
        StCord: st_q <= StWaitCo;
        StWaitCo: if (co_done) begin
          if (a == 16'sd0) acc_q <= '0;
          else if (hyp_q == 29'd0) acc_q <= a[15] ? -DegNinety : DegNinety;
          else acc_q <= co_z;
          st_q <= StMulG;
        end
        StMulG: begin
          pred_q <= 64'(kept_q[ax_q]) + (64'(m_p) >>> 16);
          st_q <= StMulA;
        end
        StMulA: begin
          term_q <= 64'(m_p);
          st_q <= StMulB;
        end
        StMulB: st_q <= StSum;
        StSum: begin
          kept_q[ax_q] <= sat;
          if (ax_q == 2'd2) begin
            // roll and pitch of this item are already kept
            if (hand_off) begin
              out_q <= {sat, kept_q[1], kept_q[0]};
              st_q <= StIdle;
            end
          end else begin
            ax_q <= ax_q + 2'd1;
            st_q <= StSqrt;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
